// ----- rtl/pace_pkg.sv -----
// Shared types and constants for the polygon area and convexity engine.
package pace_pkg;

    localparam int COORD_BITS   = 16;
    localparam int FRAC_BITS    = 8;
    localparam int MAX_VERTICES = 256;
    localparam int CNT_BITS     = 9;
    localparam int DIFF_BITS    = COORD_BITS + 1;
    localparam int PROD_BITS    = 2 * DIFF_BITS;
    localparam int CROSS_BITS   = PROD_BITS + 1;
    localparam int SUM_BITS     = 42;
    localparam int AREA_BITS    = 41;
    localparam int TRI_BITS     = 34;
    localparam int LEN_BITS     = 33;
    localparam int RAD_BITS     = 2 * DIFF_BITS + 2 * FRAC_BITS;
    localparam int ROOT_BITS    = RAD_BITS / 2;
    localparam int ROOT_STEPS   = ROOT_BITS;
    localparam int STEP_BITS    = $clog2(ROOT_STEPS + 1);
    localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_A,
        ST_MUL_B,
        ST_ROOT,
        ST_ACC,
        ST_CL_A,
        ST_CL_B,
        ST_CL_C,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL_A,
        OP_MUL_B,
        OP_ROOT,
        OP_ACC,
        OP_CL_A,
        OP_CL_B
    } op_t;

    typedef struct packed {
        op_t  op;
        logic cl_c;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic last;
        logic skip;
        logic has_edge;
        logic root_done;
        logic out_busy;
    } stat_t;

endpackage

// ----- rtl/pace_if.sv -----
// Valid/ready channel interfaces for vertices and results.
interface pace_vertex_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [pace_pkg::COORD_BITS-1:0] vertex_x;
    logic signed [pace_pkg::COORD_BITS-1:0] vertex_y;
    logic                                 last_vertex;
    modport source (output valid, vertex_x, vertex_y, last_vertex, input ready);
    modport sink (input valid, vertex_x, vertex_y, last_vertex, output ready);
endinterface

interface pace_result_if;
    logic                               valid;
    logic                               ready;
    logic [pace_pkg::CNT_BITS-1:0]      vertex_count;
    logic [pace_pkg::AREA_BITS-1:0]     area_twice;
    logic [pace_pkg::TRI_BITS-1:0]      triangle_area_twice;
    logic [pace_pkg::LEN_BITS-1:0]      path_length;
    logic                               is_convex;
    logic                               too_many;
    modport source (output valid, vertex_count, area_twice, triangle_area_twice,
                    path_length, is_convex, too_many, input ready);
    modport sink (input valid, vertex_count, area_twice, triangle_area_twice,
                  path_length, is_convex, too_many, output ready);
endinterface

// ----- rtl/pace_ctrl.sv -----
// Controller state machine sequencing one vertex through the datapath.
module pace_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  pace_pkg::stat_t  stat,
    output pace_pkg::cmd_t   cmd
);
    pace_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pace_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pace_pkg::ST_IDLE:  if (in_valid) state_next = pace_pkg::ST_MUL_A;
            pace_pkg::ST_MUL_A: state_next = pace_pkg::ST_MUL_B;
            pace_pkg::ST_MUL_B:
            begin
                if (stat.skip || !stat.has_edge)
                    state_next = stat.last ? pace_pkg::ST_CL_A : pace_pkg::ST_IDLE;
                else
                    state_next = pace_pkg::ST_ROOT;
            end
            pace_pkg::ST_ROOT:  if (stat.root_done) state_next = pace_pkg::ST_ACC;
            pace_pkg::ST_ACC:
                state_next = stat.last ? pace_pkg::ST_CL_A : pace_pkg::ST_IDLE;
            pace_pkg::ST_CL_A:  state_next = pace_pkg::ST_CL_B;
            pace_pkg::ST_CL_B:  state_next = pace_pkg::ST_CL_C;
            pace_pkg::ST_CL_C:  state_next = pace_pkg::ST_OUT;
            pace_pkg::ST_OUT:   if (!stat.out_busy) state_next = pace_pkg::ST_IDLE;
            default:            state_next = pace_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op       = pace_pkg::OP_NONE;
        cmd.cl_c     = 1'b0;
        cmd.out_load = 1'b0;
        in_ready     = 1'b0;
        unique case (state_reg)
            pace_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid) cmd.op = pace_pkg::OP_LOAD;
            end
            pace_pkg::ST_MUL_A: cmd.op = pace_pkg::OP_MUL_A;
            pace_pkg::ST_MUL_B: cmd.op = pace_pkg::OP_MUL_B;
            pace_pkg::ST_ROOT:  cmd.op = pace_pkg::OP_ROOT;
            pace_pkg::ST_ACC:   cmd.op = pace_pkg::OP_ACC;
            pace_pkg::ST_CL_A:  cmd.op = pace_pkg::OP_CL_A;
            pace_pkg::ST_CL_B:  cmd.op = pace_pkg::OP_CL_B;
            pace_pkg::ST_CL_C:  cmd.cl_c = 1'b1;
            pace_pkg::ST_OUT:   cmd.out_load = !stat.out_busy;
            default:            cmd.op = pace_pkg::OP_NONE;
        endcase
    end

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == pace_pkg::OP_LOAD |-> in_ready)
        else $error("load outside idle");
    a_out_once: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> state_reg == pace_pkg::ST_IDLE)
        else $error("result load did not return to idle");
    a_root_acc: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == pace_pkg::ST_ROOT && stat.root_done |=> state_reg == pace_pkg::ST_ACC)
        else $error("root finish missed");
endmodule

// ----- rtl/pace_datapath.sv -----
// Datapath: vertex store, products, bit-serial edge root, sums and result register.
module pace_datapath (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic signed [pace_pkg::COORD_BITS-1:0] vx,
    input  logic signed [pace_pkg::COORD_BITS-1:0] vy,
    input  logic                                   vlast,
    input  pace_pkg::cmd_t                         cmd,
    output pace_pkg::stat_t                        stat,
    pace_result_if.source                          res
);
    localparam int CB = pace_pkg::COORD_BITS;
    localparam int DB = pace_pkg::DIFF_BITS;
    localparam int PB = pace_pkg::PROD_BITS;
    localparam int XB = pace_pkg::CROSS_BITS;
    localparam int SB = pace_pkg::SUM_BITS;
    localparam int RB = pace_pkg::RAD_BITS;
    localparam int QB = pace_pkg::ROOT_BITS;

    logic signed [CB-1:0] fx_reg, fy_reg, sx_reg, sy_reg, px_reg, py_reg, ox_reg, oy_reg;
    logic signed [CB-1:0] cx_reg, cy_reg;
    logic                 last_reg, skip_reg;
    logic [pace_pkg::CNT_BITS-1:0] cnt_reg;
    logic                 ovf_reg;
    logic signed [SB-1:0] shoe_reg;
    logic [pace_pkg::LEN_BITS-1:0] len_reg;
    logic signed [XB-1:0] tri_reg;
    logic [1:0]           turn_reg;
    logic signed [PB-1:0] pa_reg, pb_reg, pc_reg, pd_reg, pe_reg;
    logic [RB-1:0]        rem_reg;
    logic [RB-1:0]        root_reg;
    logic [pace_pkg::STEP_BITS-1:0] step_reg;
    logic                 out_v_reg;
    logic [pace_pkg::CNT_BITS-1:0]  o_cnt_reg;
    logic [pace_pkg::AREA_BITS-1:0] o_area_reg;
    logic [pace_pkg::TRI_BITS-1:0]  o_tri_reg;
    logic [pace_pkg::LEN_BITS-1:0]  o_len_reg;
    logic                 o_cvx_reg, o_tm_reg;

    // multiplier operands selected by operation
    logic signed [DB-1:0] m1a, m1b, m2a, m2b, m3a, m3b;
    logic signed [PB-1:0] m1, m2, m3;
    logic signed [CB-1:0] ax, ay, bx, by, qx, qy;

    always_comb
    begin
        ax = ox_reg; ay = oy_reg; bx = px_reg; by = py_reg; qx = cx_reg; qy = cy_reg;
        if (cmd.op == pace_pkg::OP_CL_A)
        begin
            qx = fx_reg; qy = fy_reg;
        end
        else if (cmd.op == pace_pkg::OP_CL_B)
        begin
            ax = px_reg; ay = py_reg; bx = fx_reg; by = fy_reg; qx = sx_reg; qy = sy_reg;
        end
        m1a = DB'(bx) - DB'(ax);
        m1b = DB'(qy) - DB'(by);
        m2a = DB'(by) - DB'(ay);
        m2b = DB'(qx) - DB'(bx);
        m3a = DB'(qx) - DB'(bx);
        m3b = DB'(qy) + DB'(by);
        if (cmd.op == pace_pkg::OP_MUL_B)
        begin
            m1a = DB'(cx_reg) - DB'(px_reg);
            m1b = m1a;
            m2a = DB'(cy_reg) - DB'(py_reg);
            m2b = m2a;
        end
        else if (cmd.op == pace_pkg::OP_CL_B)
        begin
            m3a = DB'(fx_reg) - DB'(px_reg);
            m3b = DB'(fy_reg) + DB'(py_reg);
        end
        m1 = m1a * m1b;
        m2 = m2a * m2b;
        m3 = m3a * m3b;
    end

    logic signed [XB-1:0] zc;
    assign zc = XB'(pa_reg) - XB'(pb_reg);

    logic [RB-1:0] tb;
    logic [RB:0]   trial;
    assign tb    = {{(RB-2){1'b0}}, 2'b01} << (2 * (pace_pkg::ROOT_STEPS - 32'(step_reg)));
    assign trial = {1'b0, rem_reg} - ({1'b0, root_reg} | {1'b0, tb});

    logic [pace_pkg::LEN_BITS:0] lsum;
    assign lsum = {1'b0, len_reg} + (pace_pkg::LEN_BITS+1)'(root_reg[QB-1:0]);

    logic signed [SB-1:0] s_fin;
    logic [1:0]           t_fin;
    assign s_fin = shoe_reg + SB'(pc_reg);

    function automatic logic [1:0] sgn(input logic signed [XB-1:0] z);
        sgn = {z > 0, z < 0};
    endfunction

    assign stat.last      = last_reg;
    assign stat.skip      = skip_reg;
    assign stat.has_edge  = cnt_reg != '0;
    assign stat.root_done = step_reg == pace_pkg::STEP_BITS'(pace_pkg::ROOT_STEPS);
    assign stat.out_busy  = out_v_reg && !res.ready;

    assign t_fin = turn_reg;

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            pace_pkg::OP_LOAD:
            begin
                cx_reg <= vx; cy_reg <= vy; last_reg <= vlast;
                skip_reg <= cnt_reg >= pace_pkg::CNT_BITS'(pace_pkg::MAX_VERTICES);
            end
            pace_pkg::OP_MUL_A:
            begin
                pa_reg <= m1; pb_reg <= m2; pc_reg <= m3;
            end
            pace_pkg::OP_MUL_B:
            begin
                pd_reg <= m1; pe_reg <= m2;
                rem_reg <= RB'(PB'(m1) + PB'(m2)) << (2 * pace_pkg::FRAC_BITS);
                root_reg <= '0;
                step_reg <= '0;
            end
            pace_pkg::OP_ROOT:
            begin
                if (!trial[RB])
                begin
                    rem_reg  <= trial[RB-1:0];
                    root_reg <= (root_reg >> 1) | tb;
                end
                else
                begin
                    root_reg <= root_reg >> 1;
                end
                step_reg <= step_reg + 1'b1;
            end
            pace_pkg::OP_CL_A:
            begin
                pa_reg <= m1; pb_reg <= m2;
            end
            pace_pkg::OP_CL_B:
            begin
                pa_reg <= m1; pb_reg <= m2; pc_reg <= m3;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fx_reg <= '0; fy_reg <= '0; sx_reg <= '0; sy_reg <= '0;
            px_reg <= '0; py_reg <= '0; ox_reg <= '0; oy_reg <= '0;
            cnt_reg <= '0; ovf_reg <= 1'b0; shoe_reg <= '0; len_reg <= '0;
            tri_reg <= '0; turn_reg <= '0; out_v_reg <= 1'b0;
        end
        else
        begin
            if (res.ready) out_v_reg <= 1'b0;
            if (cmd.op == pace_pkg::OP_MUL_B)
            begin
                if (skip_reg)
                begin
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    if (cnt_reg == 0)
                    begin
                        fx_reg <= cx_reg; fy_reg <= cy_reg;
                    end
                    else if (cnt_reg == 1)
                    begin
                        sx_reg <= cx_reg; sy_reg <= cy_reg;
                    end
                    else
                    begin
                        turn_reg <= turn_reg | sgn(zc);
                        if (cnt_reg == 2) tri_reg <= zc;
                    end
                    if (cnt_reg != 0) shoe_reg <= shoe_reg + SB'(pc_reg);
                    ox_reg <= px_reg; oy_reg <= py_reg;
                    px_reg <= cx_reg; py_reg <= cy_reg;
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            if (cmd.op == pace_pkg::OP_ACC)
                len_reg <= lsum[pace_pkg::LEN_BITS] ? pace_pkg::LEN_MAX
                                                     : lsum[pace_pkg::LEN_BITS-1:0];
            if (cmd.op == pace_pkg::OP_CL_B && cnt_reg >= 3)
                turn_reg <= turn_reg | sgn(zc);
            if (cmd.cl_c)
            begin
                if (cnt_reg >= 3) turn_reg <= turn_reg | sgn(zc);
                shoe_reg <= s_fin;
            end
            if (cmd.out_load)
            begin
                out_v_reg  <= 1'b1;
                o_cnt_reg  <= cnt_reg;
                o_area_reg <= pace_pkg::AREA_BITS'(shoe_reg < 0 ? -shoe_reg : shoe_reg);
                o_tri_reg  <= cnt_reg >= 3
                    ? pace_pkg::TRI_BITS'(tri_reg < 0 ? -tri_reg : tri_reg) : '0;
                o_len_reg  <= len_reg;
                o_cvx_reg  <= cnt_reg >= 3 && (t_fin == 2'b01 || t_fin == 2'b10);
                o_tm_reg   <= ovf_reg;
                fx_reg <= '0; fy_reg <= '0; sx_reg <= '0; sy_reg <= '0;
                px_reg <= '0; py_reg <= '0; ox_reg <= '0; oy_reg <= '0;
                cnt_reg <= '0; ovf_reg <= 1'b0; shoe_reg <= '0; len_reg <= '0;
                tri_reg <= '0; turn_reg <= '0;
            end
        end
    end

    assign res.valid               = out_v_reg;
    assign res.vertex_count        = o_cnt_reg;
    assign res.area_twice          = o_area_reg;
    assign res.triangle_area_twice = o_tri_reg;
    assign res.path_length         = o_len_reg;
    assign res.is_convex           = o_cvx_reg;
    assign res.too_many            = o_tm_reg;

    logic unused_ok;
    assign unused_ok = ^{pd_reg, pe_reg};

    a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= pace_pkg::CNT_BITS'(pace_pkg::MAX_VERTICES))
        else $error("vertex count beyond maximum");
    a_cvx_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load && cnt_reg < 3 |=> !o_cvx_reg)
        else $error("convex with too few vertices");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg && !res.ready |=> out_v_reg)
        else $error("result dropped while stalled");
endmodule

// ----- rtl/polygon_area_convexity_engine.sv -----
// Top level of the polygon area and convexity engine.
// A vertex with no incoming edge, or one past MAX_VERTICES, passes only through the load
// and multiply states; otherwise the edge length comes from a restoring square root over
// a 50-bit radicand that spends one setup step and then retires one of its 25 result bits
// per cycle. A marked vertex adds the wrap-around terms and a result load; the result
// register lets the next polygon start as soon as the result is registered.
module polygon_area_convexity_engine (
    input  logic          clk,
    input  logic          rst_n,
    pace_vertex_if.sink   vertex,
    pace_result_if.source result
);
    pace_pkg::cmd_t  cmd;
    pace_pkg::stat_t stat;

    pace_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (vertex.valid),
        .in_ready (vertex.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pace_datapath u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .vx    (vertex.vertex_x),
        .vy    (vertex.vertex_y),
        .vlast (vertex.last_vertex),
        .cmd   (cmd),
        .stat  (stat),
        .res   (result)
    );
endmodule
